/* rtl/core/iks_pkg.sv */
// shared constants and types of the integer key sorter
package iks_pkg;

  localparam int KEY_BITS = 31;
  localparam int MAX_KEYS = 64;
  localparam int CNT_BITS = $clog2(MAX_KEYS + 1);
  localparam int DATA_W   = ((KEY_BITS + 7) / 8) * 8;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } chain_cmd_t;

endpackage

/* rtl/core/iks_cell.sv */
// one compare-and-shift cell of the sorting chain
module iks_cell import iks_pkg::*; (
  input  logic       clk_i,
  input  chain_cmd_t cmd_i,
  input  logic       occ_i,
  input  key_t       new_key_i,
  input  key_t       left_key_i,
  input  logic       left_big_i,
  input  key_t       right_key_i,
  output key_t       key_o,
  output logic       big_o
);

  key_t key_q, key_d;

  // an empty cell counts as holding a key larger than any new one
  assign big_o = !occ_i || (key_q > new_key_i);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (cmd_i.shift) begin
      key_d = right_key_i;
    end else if (cmd_i.ins && big_o) begin
      key_d = left_big_i ? left_key_i : new_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

/* rtl/core/iks_chain.sv */
// row of sorting cells, kept in ascending order from cell zero up
module iks_chain import iks_pkg::*; (
  input  logic       clk_i,
  input  chain_cmd_t cmd_i,
  input  cnt_t       count_i,
  input  key_t       new_key_i,
  output key_t       head_key_o
);

  key_t key_w [MAX_KEYS];
  logic big_w [MAX_KEYS];

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    key_t left_key, right_key;
    logic left_big, occ;

    assign occ = (CNT_BITS'(i) < count_i);

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_big = 1'b0;
    end else begin : g_mid
      assign left_key = key_w[i-1];
      assign left_big = big_w[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_nxt
      assign right_key = key_w[i+1];
    end

    iks_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .occ_i       (occ),
      .new_key_i   (new_key_i),
      .left_key_i  (left_key),
      .left_big_i  (left_big),
      .right_key_i (right_key),
      .key_o       (key_w[i]),
      .big_o       (big_w[i])
    );
  end

  assign head_key_o = key_w[0];

endmodule

/* rtl/core/integer_key_sorter_core.sv */
// top level of the integer key sorter
//
// keys of one group enter on the slave stream, one word per cycle while
// tready is high, with tlast on the final key of the group. each key is
// placed into a chain of compare-and-shift cells in the cycle it is
// accepted, so the chain always holds the group in ascending order. at most
// MAX_KEYS keys are held; later keys of the group are dropped and every
// result of that group carries tuser (overflow) high.
// the word with tlast starts the run: the slave side drops tready and the
// chain shifts one key per cycle toward the head into the output register
// while the master side takes them; the largest comes last with tlast high.
// a group thus holds off input until its run is out; both sides move one
// key per cycle when not held, set by the single shared chain.
// a stall on the master side freezes the chain with the output register
// full. reset empties the chain count and the overflow flag and leaves the
// block ready for a new group; key contents are not cleared.
module integer_key_sorter_core import iks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // key
  input  logic              s_axis_tlast_i,  // is_last
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,  // sorted_key
  output logic              m_axis_tlast_o,  // end_of_run
  output logic              m_axis_tuser_o   // overflow
);

  state_e     state_q, state_d;
  cnt_t       count_q, count_d;
  logic       drop_q, drop_d;
  logic       out_vld_q, out_vld_d;
  key_t       out_key_q;
  logic       out_last_q, out_ovf_q;
  key_t       head_key;
  chain_cmd_t cmd;
  logic       accept, full, step, final_step;

  assign full       = (count_q == CNT_BITS'(MAX_KEYS));
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign step       = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready_i);
  assign final_step = step && (count_q == CNT_BITS'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && s_axis_tlast_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (final_step) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd.ins         = 1'b0;
    cmd.shift       = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        cmd.ins         = s_axis_tvalid_i && !full;
      end
      ST_EMIT: begin
        cmd.shift = step;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (step) begin
      count_d = count_q - CNT_BITS'(1);
    end
    drop_d = drop_q;
    if (accept && full) begin
      drop_d = 1'b1;
    end else if (final_step) begin
      drop_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      drop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_key_q  <= head_key;
      out_last_q <= (count_q == CNT_BITS'(1));
      out_ovf_q  <= drop_q;
    end
  end

  iks_chain u_chain (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .count_i    (count_q),
    .new_key_i  (s_axis_tdata_i[KEY_BITS-1:0]),
    .head_key_o (head_key)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = DATA_W'(out_key_q);
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule

/* rtl/core/iks_checker.sv */
// port-level checks of the integer key sorter, bound to the top level
module iks_checker import iks_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              s_axis_tlast_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [DATA_W-1:0] m_axis_tdata_o,
  input logic              m_axis_tlast_o,
  input logic              m_axis_tuser_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // the word that closes a group stops input until the run is out
  a_run_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken right after end of group");

  // input reopens only with the last word of the run waiting
  a_reopen_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("input reopened before run was complete");

  // overflow flag is the same on every word of a run
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o && !s_axis_tready_o
      |=> m_axis_tvalid_o && $stable(m_axis_tuser_o))
    else $error("overflow flag changed within a run");

endmodule

bind integer_key_sorter_core iks_checker u_iks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
